### hw/rtl/sprite_velocity_integrator_defines.svh
// ----------------------------------------------------------------------------
// Sprite velocity integrator: assertion macros
// Shared property forms for the checker of the integrator's ports.
// ----------------------------------------------------------------------------
`ifndef SPRITE_VELOCITY_INTEGRATOR_DEFINES_SVH
`define SPRITE_VELOCITY_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SVI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SVI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/svi_pkg.sv
// ----------------------------------------------------------------------------
// Sprite velocity integrator package
// Widths, codes and saturating helpers shared by the integrator files.
// ----------------------------------------------------------------------------
package svi_pkg;

   localparam int VALUE_W       = 32;
   localparam int DELTA_W       = 16;
   localparam int DELTA_FRAC    = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int OPCODE_W      = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FORCE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_IMPULSE = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GRAV_EN   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GRAV_ACC  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GRAV_FAC  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MASS      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DRAG      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_FRICTION  = 3'd6;

   localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_NONE      = 2'd0,
      MODE_DYNAMIC   = 2'd1,
      MODE_KINEMATIC = 2'd2,
      MODE_STATIC    = 2'd3
   } phys_mode_type;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] numer;
      logic [VALUE_W-1:0] denom;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [VALUE_W:0] quot;
   } div_res_type;

   // Magnitude of a signed value; the most negative value maps to 2^(W-1).
   function automatic logic [VALUE_W-1:0] mag_of(input logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] u;
      u = v;
      return v[VALUE_W-1] ? (~u + 1'b1) : u;
   endfunction

   // base +/- amount, saturated to the signed value range.
   function automatic logic signed [VALUE_W-1:0] sat_add(
      input logic signed [VALUE_W-1:0] base,
      input logic        [VALUE_W:0]   amount,
      input logic                      neg
   );
      logic signed [VALUE_W+1:0] wide_base;
      logic signed [VALUE_W+1:0] wide_amt;
      logic signed [VALUE_W+1:0] total;
      wide_base = (VALUE_W+2)'(base);
      wide_amt  = $signed({1'b0, amount});
      total     = neg ? (wide_base - wide_amt) : (wide_base + wide_amt);
      if (total > (VALUE_W+2)'(VMAX)) begin
         return VMAX;
      end else if (total < (VALUE_W+2)'(VMIN)) begin
         return VMIN;
      end
      return VALUE_W'(total);
   endfunction

endpackage

### hw/rtl/svi_if.sv
// ----------------------------------------------------------------------------
// Sprite velocity integrator channels
// Valid/ready item channels for requests and responses.
// ----------------------------------------------------------------------------
interface svi_req_if;
   import svi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic signed [VALUE_W-1:0]  vec_x;
   logic signed [VALUE_W-1:0]  vec_y;
   logic signed [VALUE_W-1:0]  vel_in_x;
   logic signed [VALUE_W-1:0]  vel_in_y;
   logic signed [VALUE_W-1:0]  pos_in_x;
   logic signed [VALUE_W-1:0]  pos_in_y;
   logic [DELTA_W-1:0]         tick_delta;
   logic                       on_floor;

   modport source (
      output valid, opcode, vec_x, vec_y, vel_in_x, vel_in_y, pos_in_x, pos_in_y,
             tick_delta, on_floor,
      input  ready
   );
   modport sink (
      input  valid, opcode, vec_x, vec_y, vel_in_x, vel_in_y, pos_in_x, pos_in_y,
             tick_delta, on_floor,
      output ready
   );
endinterface

interface svi_rsp_if;
   import svi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  vel_out_x;
   logic signed [VALUE_W-1:0]  vel_out_y;
   logic signed [VALUE_W-1:0]  pos_out_x;
   logic signed [VALUE_W-1:0]  pos_out_y;

   modport source (
      output valid, vel_out_x, vel_out_y, pos_out_x, pos_out_y,
      input  ready
   );
   modport sink (
      input  valid, vel_out_x, vel_out_y, pos_out_x, pos_out_y,
      output ready
   );
endinterface

### hw/rtl/svi_divider.sv
// ----------------------------------------------------------------------------
// Sprite velocity integrator divider
// Restoring divider, one quotient bit per cycle: round((numer << FRAC_BITS)
// / denom) to nearest, clipped to 2^VALUE_W.
// ----------------------------------------------------------------------------
module svi_divider #(
   parameter int FRAC_BITS = svi_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  svi_pkg::div_cmd_type cmd,
   output svi_pkg::div_res_type res
);
   import svi_pkg::*;

   localparam int NUM_W = VALUE_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_ROUND
   } dv_state_type;

   dv_state_type       state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [VALUE_W-1:0] rem_ff;
   logic [VALUE_W-1:0] den_ff;
   logic               done_ff;
   logic [VALUE_W:0]   quot_ff;

   logic [VALUE_W:0]   rem_shift_in;
   logic               ge_in;
   logic [VALUE_W-1:0] rem_in;
   logic               round_up_in;
   logic [NUM_W:0]     q_round_in;
   logic [VALUE_W:0]   quot_in;

   always_comb begin
      rem_shift_in = {rem_ff, num_ff[NUM_W-1]};
      ge_in        = (rem_shift_in >= {1'b0, den_ff});
      rem_in       = ge_in ? VALUE_W'(rem_shift_in - {1'b0, den_ff})
                           : VALUE_W'(rem_shift_in);
      // round half up on the remainder: 2*rem >= den
      round_up_in  = ({rem_ff, 1'b0} >= {1'b0, den_ff});
      q_round_in   = (NUM_W+1)'(num_ff) + (NUM_W+1)'(round_up_in);
      if (|q_round_in[NUM_W:VALUE_W]) begin
         quot_in = {1'b1, {VALUE_W{1'b0}}};
      end else begin
         quot_in = q_round_in[VALUE_W:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DV_IDLE: begin
               if (cmd.start) begin
                  num_ff   <= {cmd.numer, {FRAC_BITS{1'b0}}};
                  rem_ff   <= '0;
                  den_ff   <= cmd.denom;
                  cnt_ff   <= CNT_W'(NUM_W);
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               // quotient bits shift in behind the dividend bits
               num_ff <= {num_ff[NUM_W-2:0], ge_in};
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= DV_ROUND;
               end
            end
            DV_ROUND: begin
               quot_ff  <= quot_in;
               done_ff  <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;

endmodule

### hw/rtl/sprite_velocity_integrator.sv
// ----------------------------------------------------------------------------
// Sprite velocity integrator
// Integrates one sprite body's 2D velocity per tick in signed fixed point
// (32 bits, FRAC_BITS fraction bits; tick length unsigned Q0.16). Force and
// impulse items add into saturating running sums, only in dynamic mode, and
// give no response; opcode 3 and events outside dynamic mode are dropped. A
// tick item gives one response. Dynamic ticks apply gravity off the floor,
// impulse*dt/mass, force*dt, drag scaling and floor friction, then clear the
// impulse sum; kinematic ticks pass through; static ticks zero velocity and
// both sums; no-physics ticks advance position by velocity*dt and clear the
// sums. One 32x32 multiplier with a registered rounding stage is reused by a
// step sequencer; each multiply step runs operand load, product, round and
// apply, and each impulse component with nonzero mass adds a bit-serial
// division between round and apply. The block takes one item at a time; a
// finished response sits in an output register, so the next item is accepted
// while it waits. Registers sit on an APB-style port at byte address 4*index.
// ----------------------------------------------------------------------------
module sprite_velocity_integrator #(
   parameter int FRAC_BITS = svi_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   svi_req_if.sink                          req,
   svi_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [svi_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [svi_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [svi_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import svi_pkg::*;

   // 1.0 in the value format
   localparam logic [VALUE_W-1:0] ONE_FIX = VALUE_W'(1) << FRAC_BITS;
   localparam int PROD_W = 2 * VALUE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MULT,
      ST_ROUND,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_APPLY,
      ST_FINISH
   } state_type;

   // Work steps of a tick, in the order they run.
   typedef enum logic [3:0] {
      SP_GRAV_DT,
      SP_GRAV_FAC,
      SP_IMP_X,
      SP_IMP_Y,
      SP_FORCE_X,
      SP_FORCE_Y,
      SP_DRAG_K,
      SP_DRAG_X,
      SP_DRAG_Y,
      SP_FRIC,
      SP_POS_X,
      SP_POS_Y
   } step_type;

   // ---------------------------------------------------------------- config
   phys_mode_type              mode_ff;
   logic                       grav_en_ff;
   logic signed [VALUE_W-1:0]  grav_accel_ff;
   logic [VALUE_W-1:0]         grav_factor_ff;
   logic [VALUE_W-1:0]         mass_ff;
   logic [VALUE_W-1:0]         drag_ff;
   logic [VALUE_W-1:0]         fric_ff;

   logic                       csr_wr;
   logic [REG_IDX_W-1:0]       csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   // Write the selected register on the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NONE;
         grav_en_ff     <= 1'b0;
         grav_accel_ff  <= '0;
         grav_factor_ff <= ONE_FIX;
         mass_ff        <= ONE_FIX;
         drag_ff        <= '0;
         fric_ff        <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MODE:     mode_ff        <= phys_mode_type'(csr_pwdata[1:0]);
            REG_GRAV_EN:  grav_en_ff     <= csr_pwdata[0];
            REG_GRAV_ACC: grav_accel_ff  <= $signed(csr_pwdata[VALUE_W-1:0]);
            REG_GRAV_FAC: grav_factor_ff <= csr_pwdata[VALUE_W-1:0];
            REG_MASS:     mass_ff        <= csr_pwdata[VALUE_W-1:0];
            REG_DRAG:     drag_ff        <= csr_pwdata[VALUE_W-1:0];
            REG_FRICTION: fric_ff        <= csr_pwdata[VALUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back, zero extended.
   always_comb begin
      case (csr_idx)
         REG_MODE:     csr_prdata = CSR_DATA_W'(mode_ff);
         REG_GRAV_EN:  csr_prdata = CSR_DATA_W'(grav_en_ff);
         REG_GRAV_ACC: csr_prdata = CSR_DATA_W'(unsigned'(grav_accel_ff));
         REG_GRAV_FAC: csr_prdata = CSR_DATA_W'(grav_factor_ff);
         REG_MASS:     csr_prdata = CSR_DATA_W'(mass_ff);
         REG_DRAG:     csr_prdata = CSR_DATA_W'(drag_ff);
         REG_FRICTION: csr_prdata = CSR_DATA_W'(fric_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // --------------------------------------------------------------- datapath
   state_type                  state_ff;
   step_type                   step_ff;

   logic signed [VALUE_W-1:0]  force_x_ff;
   logic signed [VALUE_W-1:0]  force_y_ff;
   logic signed [VALUE_W-1:0]  imp_x_ff;
   logic signed [VALUE_W-1:0]  imp_y_ff;

   logic signed [VALUE_W-1:0]  vx_ff;
   logic signed [VALUE_W-1:0]  vy_ff;
   logic signed [VALUE_W-1:0]  px_ff;
   logic signed [VALUE_W-1:0]  py_ff;
   logic [DELTA_W-1:0]         dt_ff;
   logic                       floor_ff;

   logic [VALUE_W-1:0]         mul_a_ff;
   logic [VALUE_W-1:0]         mul_b_ff;
   logic                       neg_ff;       // sign of the current product
   logic                       frac_sh_ff;   // shift by FRAC_BITS, else by dt bits
   logic [PROD_W-1:0]          prod_ff;
   logic [VALUE_W:0]           rnd_ff;       // rounded magnitude, clipped to 2^W
   logic [VALUE_W-1:0]         scale_ff;     // 1 - drag*dt

   logic                       rsp_valid_ff;
   logic signed [VALUE_W-1:0]  out_vx_ff;
   logic signed [VALUE_W-1:0]  out_vy_ff;
   logic signed [VALUE_W-1:0]  out_px_ff;
   logic signed [VALUE_W-1:0]  out_py_ff;

   logic [VALUE_W-1:0]         dt_wide;
   logic [PROD_W-1:0]          prod_in;
   logic [PROD_W:0]            round_sum_in;
   logic [PROD_W:0]            round_shift_in;
   logic [VALUE_W:0]           rnd_in;

   div_cmd_type                div_cmd;
   div_res_type                div_res;

   assign dt_wide = VALUE_W'(dt_ff);
   assign prod_in = PROD_W'(mul_a_ff) * PROD_W'(mul_b_ff);

   // Round the product to nearest (ties away from zero on the magnitude),
   // drop the fraction, clip anything at or past 2^W, which saturates anyway.
   always_comb begin
      if (frac_sh_ff) begin
         round_sum_in   = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
         round_shift_in = round_sum_in >> FRAC_BITS;
      end else begin
         round_sum_in   = {1'b0, prod_ff} + ((PROD_W+1)'(1) << (DELTA_FRAC - 1));
         round_shift_in = round_sum_in >> DELTA_FRAC;
      end
      if (|round_shift_in[PROD_W:VALUE_W]) begin
         rnd_in = {1'b1, {VALUE_W{1'b0}}};
      end else begin
         rnd_in = round_shift_in[VALUE_W:0];
      end
   end

   // Impulse over mass goes through the serial divider.
   assign div_cmd.start = (state_ff == ST_DIV_GO);
   assign div_cmd.numer = rnd_ff[VALUE_W-1:0];
   assign div_cmd.denom = mass_ff;

   svi_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // ------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SP_GRAV_DT;
         rsp_valid_ff <= 1'b0;
         force_x_ff   <= '0;
         force_y_ff   <= '0;
         imp_x_ff     <= '0;
         imp_y_ff     <= '0;
      end else begin
         // drop the response once taken; a new one below overrides
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  if (req.opcode == OP_TICK) begin
                     vx_ff    <= req.vel_in_x;
                     vy_ff    <= req.vel_in_y;
                     px_ff    <= req.pos_in_x;
                     py_ff    <= req.pos_in_y;
                     dt_ff    <= req.tick_delta;
                     floor_ff <= req.on_floor;
                     case (mode_ff)
                        MODE_DYNAMIC: begin
                           step_ff  <= SP_GRAV_DT;
                           state_ff <= ST_LOAD;
                        end
                        MODE_NONE: begin
                           step_ff  <= SP_POS_X;
                           state_ff <= ST_LOAD;
                        end
                        MODE_STATIC: begin
                           vx_ff    <= '0;
                           vy_ff    <= '0;
                           state_ff <= ST_FINISH;
                        end
                        default: begin
                           state_ff <= ST_FINISH;
                        end
                     endcase
                  end else if (mode_ff == MODE_DYNAMIC) begin
                     // accumulate events; no response
                     if (req.opcode == OP_FORCE) begin
                        force_x_ff <= sat_add(force_x_ff, {1'b0, mag_of(req.vec_x)},
                                              req.vec_x[VALUE_W-1]);
                        force_y_ff <= sat_add(force_y_ff, {1'b0, mag_of(req.vec_y)},
                                              req.vec_y[VALUE_W-1]);
                     end else if (req.opcode == OP_IMPULSE) begin
                        imp_x_ff <= sat_add(imp_x_ff, {1'b0, mag_of(req.vec_x)},
                                            req.vec_x[VALUE_W-1]);
                        imp_y_ff <= sat_add(imp_y_ff, {1'b0, mag_of(req.vec_y)},
                                            req.vec_y[VALUE_W-1]);
                     end
                  end
               end
            end

            ST_LOAD: begin
               // pick operands for the step, or skip it
               frac_sh_ff <= 1'b0;
               mul_b_ff   <= dt_wide;
               state_ff   <= ST_MULT;
               case (step_ff)
                  SP_GRAV_DT: begin
                     if (grav_en_ff && !floor_ff) begin
                        mul_a_ff <= mag_of(grav_accel_ff);
                        neg_ff   <= grav_accel_ff[VALUE_W-1];
                     end else begin
                        step_ff  <= SP_IMP_X;
                        state_ff <= ST_LOAD;
                     end
                  end
                  SP_GRAV_FAC: begin
                     // gravity*dt is in rnd_ff, its sign still in neg_ff
                     mul_a_ff   <= rnd_ff[VALUE_W-1:0];
                     mul_b_ff   <= grav_factor_ff;
                     frac_sh_ff <= 1'b1;
                  end
                  SP_IMP_X: begin
                     mul_a_ff <= mag_of(imp_x_ff);
                     neg_ff   <= imp_x_ff[VALUE_W-1];
                  end
                  SP_IMP_Y: begin
                     mul_a_ff <= mag_of(imp_y_ff);
                     neg_ff   <= imp_y_ff[VALUE_W-1];
                  end
                  SP_FORCE_X: begin
                     mul_a_ff <= mag_of(force_x_ff);
                     neg_ff   <= force_x_ff[VALUE_W-1];
                  end
                  SP_FORCE_Y: begin
                     mul_a_ff <= mag_of(force_y_ff);
                     neg_ff   <= force_y_ff[VALUE_W-1];
                  end
                  SP_DRAG_K: begin
                     if (drag_ff != '0) begin
                        mul_a_ff <= drag_ff;
                        neg_ff   <= 1'b0;
                     end else begin
                        step_ff  <= SP_FRIC;
                        state_ff <= ST_LOAD;
                     end
                  end
                  SP_DRAG_X: begin
                     mul_a_ff   <= mag_of(vx_ff);
                     mul_b_ff   <= scale_ff;
                     neg_ff     <= vx_ff[VALUE_W-1];
                     frac_sh_ff <= 1'b1;
                  end
                  SP_DRAG_Y: begin
                     mul_a_ff   <= mag_of(vy_ff);
                     mul_b_ff   <= scale_ff;
                     neg_ff     <= vy_ff[VALUE_W-1];
                     frac_sh_ff <= 1'b1;
                  end
                  SP_FRIC: begin
                     if (floor_ff && (vx_ff != '0)) begin
                        mul_a_ff <= fric_ff;
                        neg_ff   <= 1'b0;
                     end else begin
                        state_ff <= ST_FINISH;
                     end
                  end
                  SP_POS_X: begin
                     mul_a_ff <= mag_of(vx_ff);
                     neg_ff   <= vx_ff[VALUE_W-1];
                  end
                  SP_POS_Y: begin
                     mul_a_ff <= mag_of(vy_ff);
                     neg_ff   <= vy_ff[VALUE_W-1];
                  end
                  default: begin
                     state_ff <= ST_FINISH;
                  end
               endcase
            end

            ST_MULT: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ROUND;
            end

            ST_ROUND: begin
               rnd_ff <= rnd_in;
               // zero mass counts as one: skip the divide
               if ((step_ff inside {SP_IMP_X, SP_IMP_Y}) && (mass_ff != '0)) begin
                  state_ff <= ST_DIV_GO;
               end else begin
                  state_ff <= ST_APPLY;
               end
            end

            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end

            ST_DIV_WAIT: begin
               if (div_res.done) begin
                  rnd_ff   <= div_res.quot;
                  state_ff <= ST_APPLY;
               end
            end

            ST_APPLY: begin
               state_ff <= ST_LOAD;
               case (step_ff)
                  SP_GRAV_DT: begin
                     step_ff <= SP_GRAV_FAC;
                  end
                  SP_GRAV_FAC: begin
                     vy_ff   <= sat_add(vy_ff, rnd_ff, neg_ff);
                     step_ff <= SP_IMP_X;
                  end
                  SP_IMP_X: begin
                     vx_ff   <= sat_add(vx_ff, rnd_ff, neg_ff);
                     step_ff <= SP_IMP_Y;
                  end
                  SP_IMP_Y: begin
                     vy_ff   <= sat_add(vy_ff, rnd_ff, neg_ff);
                     step_ff <= SP_FORCE_X;
                  end
                  SP_FORCE_X: begin
                     vx_ff   <= sat_add(vx_ff, rnd_ff, neg_ff);
                     step_ff <= SP_FORCE_Y;
                  end
                  SP_FORCE_Y: begin
                     vy_ff   <= sat_add(vy_ff, rnd_ff, neg_ff);
                     step_ff <= SP_DRAG_K;
                  end
                  SP_DRAG_K: begin
                     // drag*dt at or past one stops the body
                     if (rnd_ff >= {1'b0, ONE_FIX}) begin
                        vx_ff   <= '0;
                        vy_ff   <= '0;
                        step_ff <= SP_FRIC;
                     end else begin
                        scale_ff <= ONE_FIX - rnd_ff[VALUE_W-1:0];
                        step_ff  <= SP_DRAG_X;
                     end
                  end
                  SP_DRAG_X: begin
                     vx_ff   <= sat_add('0, rnd_ff, neg_ff);
                     step_ff <= SP_DRAG_Y;
                  end
                  SP_DRAG_Y: begin
                     vy_ff   <= sat_add('0, rnd_ff, neg_ff);
                     step_ff <= SP_FRIC;
                  end
                  SP_FRIC: begin
                     // move x toward zero; stop it if friction overshoots
                     if ({1'b0, mag_of(vx_ff)} <= rnd_ff) begin
                        vx_ff <= '0;
                     end else begin
                        vx_ff <= sat_add(vx_ff, rnd_ff, !vx_ff[VALUE_W-1]);
                     end
                     state_ff <= ST_FINISH;
                  end
                  SP_POS_X: begin
                     px_ff   <= sat_add(px_ff, rnd_ff, neg_ff);
                     step_ff <= SP_POS_Y;
                  end
                  SP_POS_Y: begin
                     py_ff    <= sat_add(py_ff, rnd_ff, neg_ff);
                     state_ff <= ST_FINISH;
                  end
                  default: begin
                     state_ff <= ST_FINISH;
                  end
               endcase
            end

            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp.ready) begin
                  out_vx_ff    <= vx_ff;
                  out_vy_ff    <= vy_ff;
                  out_px_ff    <= px_ff;
                  out_py_ff    <= py_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  case (mode_ff)
                     MODE_DYNAMIC: begin
                        imp_x_ff <= '0;
                        imp_y_ff <= '0;
                     end
                     MODE_NONE, MODE_STATIC: begin
                        force_x_ff <= '0;
                        force_y_ff <= '0;
                        imp_x_ff   <= '0;
                        imp_y_ff   <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------ ports
   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.vel_out_x = out_vx_ff;
   assign rsp.vel_out_y = out_vy_ff;
   assign rsp.pos_out_x = out_px_ff;
   assign rsp.pos_out_y = out_py_ff;

endmodule

### hw/rtl/svi_checker.sv
// ----------------------------------------------------------------------------
// Sprite velocity integrator checker
// Port-level assertions, bound onto the integrator's top level.
// ----------------------------------------------------------------------------
`include "sprite_velocity_integrator_defines.svh"

module svi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [svi_pkg::OPCODE_W-1:0]  req_opcode,
   input logic                          rsp_valid,
   input logic                          rsp_ready
);
   import svi_pkg::*;

   // A pending response stays up until taken.
   `SVI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped before taken")

   // A tick item occupies the block for at least the next cycle.
   `SVI_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && req_ready && req_opcode == OP_TICK, !req_ready, "accepted tick did not make the block busy")

   // A new response follows a busy period and returns the block to ready.
   `SVI_ASSERT_IMPLY(a_rsp_after_work, clock, reset, $rose(rsp_valid), req_ready && $past(!req_ready), "response appeared without tick work")

   // Out of reset the block is ready and holds no response.
   `SVI_ASSERT_IMPLY(a_reset_state, clock, reset, $past(reset), req_ready && !rsp_valid, "block not idle after reset")

endmodule

bind sprite_velocity_integrator svi_checker u_svi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .req_opcode (req.opcode),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready)
);
